>>> sv/vertex_screen_projection_assert.svh
// ---------------------------------------------------------------------------
// Vertex screen projection assertion macros
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef VERTEX_SCREEN_PROJECTION_ASSERT_SVH
`define VERTEX_SCREEN_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VSP_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vsp assertion failed");
// next-cycle implication
`define VSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vsp assertion failed");
`else
`define VSP_ASSERT(lbl, ante, cons)
`define VSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> sv/vsp_pkg.sv
// ---------------------------------------------------------------------------
// vsp_pkg
// Shared widths, register codes and payload types of the projection block.
// ---------------------------------------------------------------------------
package vsp_pkg;

  localparam int IDX_W    = 16;
  localparam int POS_W    = 24;
  localparam int COEF_W   = 16;
  localparam int POS_FRAC = 8;
  localparam int PIX_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int DEPTH_W  = 24;
  localparam int ROW_W    = 64;
  localparam int N_ROWS   = 4;
  localparam int N_TERMS  = 3;
  localparam int PROD_W   = COEF_W + POS_W;   // one coefficient times one coordinate
  localparam int DOT_W    = PROD_W + 2;       // sum of four terms
  localparam int SUM_W    = DOT_W + 1;        // c + w
  localparam int MUL_W    = SUM_W + SIZE_W + 1;
  localparam int NUM_W    = MUL_W - 1;        // magnitude plus w
  localparam int DEN_W    = DOT_W;            // 2 * w
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_CLIP_X = 3'd0,
    REG_CLIP_Y = 3'd1,
    REG_CLIP_W = 3'd2,
    REG_VIEW_Z = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } vsp_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          index_out;
    logic [PIX_W-1:0]          screen_x;
    logic [PIX_W-1:0]          screen_y;
    logic signed [DEPTH_W-1:0] view_depth;
    logic                      on_screen;
  } vsp_out_t;

  typedef struct packed {
    logic [ROW_W-1:0]  clip_row_x;
    logic [ROW_W-1:0]  clip_row_y;
    logic [ROW_W-1:0]  clip_row_w;
    logic [ROW_W-1:0]  view_row_z;
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
  } vsp_cfg_t;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic [IDX_W-1:0]          index;
    logic signed [DEPTH_W-1:0] depth;
    logic                      w_pos;
    logic                      neg_x;
    logic                      neg_y;
  } vsp_meta_t;

endpackage

>>> sv/vsp_cfg.sv
// ---------------------------------------------------------------------------
// vsp_cfg
// APB register file holding the matrix rows and the window size.
// ---------------------------------------------------------------------------
module vsp_cfg import vsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output vsp_cfg_t          cfg_o
);

  vsp_cfg_t cfg_q;
  reg_idx_e sel;

  // registers sit on 8-byte boundaries
  assign sel = reg_idx_e'(paddr_i[5:3]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_row_x    <= '0;
      cfg_q.clip_row_y    <= '0;
      cfg_q.clip_row_w    <= '0;
      cfg_q.view_row_z    <= '0;
      cfg_q.screen_width  <= SIZE_W'(1);
      cfg_q.screen_height <= SIZE_W'(1);
    end else if (psel_i && penable_i && pwrite_i) begin
      unique case (sel)
        REG_CLIP_X: cfg_q.clip_row_x    <= pwdata_i;
        REG_CLIP_Y: cfg_q.clip_row_y    <= pwdata_i;
        REG_CLIP_W: cfg_q.clip_row_w    <= pwdata_i;
        REG_VIEW_Z: cfg_q.view_row_z    <= pwdata_i;
        REG_WIDTH:  cfg_q.screen_width  <= pwdata_i[SIZE_W-1:0];
        REG_HEIGHT: cfg_q.screen_height <= pwdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (sel)
      REG_CLIP_X: prdata_o = cfg_q.clip_row_x;
      REG_CLIP_Y: prdata_o = cfg_q.clip_row_y;
      REG_CLIP_W: prdata_o = cfg_q.clip_row_w;
      REG_VIEW_Z: prdata_o = cfg_q.view_row_z;
      REG_WIDTH:  prdata_o = DATA_W'(cfg_q.screen_width);
      REG_HEIGHT: prdata_o = DATA_W'(cfg_q.screen_height);
      default:    prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/vsp_dot.sv
// ---------------------------------------------------------------------------
// vsp_dot
// Four row dot products with the homogeneous position: products, then sums.
// ---------------------------------------------------------------------------
module vsp_dot import vsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [POS_W-1:0] pos_i [N_TERMS],
  input  logic [ROW_W-1:0]        row_i [N_ROWS],
  output logic signed [DOT_W-1:0] dot_o [N_ROWS]
);

  logic signed [PROD_W-1:0] prod_q [N_ROWS][N_TERMS];
  logic signed [PROD_W-1:0] trans_q [N_ROWS];
  logic signed [DOT_W-1:0]  sum_q [N_ROWS];

  for (genvar r = 0; r < N_ROWS; r++) begin : g_row
    logic signed [COEF_W-1:0] c_tr;
    assign c_tr = row_i[r][N_TERMS*COEF_W +: COEF_W];

    for (genvar k = 0; k < N_TERMS; k++) begin : g_term
      logic signed [COEF_W-1:0] c_k;
      assign c_k = row_i[r][k*COEF_W +: COEF_W];

      // stage 1: one multiplier per term
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[r][k] <= c_k * pos_i[k];
        end
      end
    end

    // translation term multiplies 1.0 in position format
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        trans_q[r] <= PROD_W'(c_tr) <<< POS_FRAC;
      end
    end

    // stage 2: four-term sum
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[r] <= DOT_W'(prod_q[r][0]) + DOT_W'(prod_q[r][1])
                  + DOT_W'(prod_q[r][2]) + DOT_W'(trans_q[r]);
      end
    end

    assign dot_o[r] = sum_q[r];
  end

endmodule

>>> sv/vsp_div.sv
// ---------------------------------------------------------------------------
// vsp_div
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
// ---------------------------------------------------------------------------
module vsp_div import vsp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [PIX_W-1:0] quot_o,
  output logic             ovf_o
);

  localparam int QW = PIX_W;

  logic [NUM_W-1:0] rem_q  [QW];
  logic [DEN_W-1:0] den_q  [QW];
  logic [QW-1:0]    quot_q [QW+1];
  logic             ovf_q  [QW+1];

  // stage 0: quotient of 2^QW or more is flagged as overflow
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= num_i >= (NUM_W'(den_i) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int B = QW - 1 - k;
    logic [NUM_W-1:0] dsh;
    logic             ge;

    assign dsh = NUM_W'(den_q[k]) << B;
    assign ge  = rem_q[k] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[k+1] <= quot_q[k] | (QW'(ge) << B);
        ovf_q[k+1]  <= ovf_q[k];
      end
    end

    // the last stage needs no remainder
    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quot_o = quot_q[QW];
  assign ovf_o  = ovf_q[QW];

endmodule

>>> sv/vertex_screen_projection.sv
// ---------------------------------------------------------------------------
// vertex_screen_projection
// Projects a vertex through the configured matrix rows to window pixels.
// ---------------------------------------------------------------------------
// Accepts one vertex per clock while in_stall_o is low and returns one result
// per vertex, in order. The request enters the first of twenty register
// stages at the accepting edge: two for the dot products, three for c + w,
// scaling by the window size and the rounding offset, thirteen for the
// divider (an overflow check, then one quotient bit per stage), one to form
// the pixel flags and the output register.
// Results leave through an output register backed by a one-entry skid buffer;
// when the skid entry is in use the whole pipeline holds and in_stall_o is
// high until the entry drains into the output register.
// Configuration may only be written while no vertex is in flight.
`include "vertex_screen_projection_assert.svh"

module vertex_screen_projection import vsp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vsp_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vsp_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int DIV_LAT = PIX_W + 1;

  vsp_cfg_t cfg;
  logic     adv;

  logic signed [POS_W-1:0] pos [N_TERMS];
  logic [ROW_W-1:0]        rows [N_ROWS];
  logic signed [DOT_W-1:0] dot [N_ROWS];

  logic             v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [IDX_W-1:0] idx1_q, idx2_q;

  logic signed [SUM_W-1:0]   ax_q, ay_q;
  logic signed [DOT_W-1:0]   cw3_q, cw4_q;
  vsp_meta_t                 m3_q, m4_q, m5_q;
  logic signed [MUL_W-1:0]   mx_q, my_q;
  logic [NUM_W-1:0]          nx_q, ny_q;
  logic [DEN_W-1:0]          den_q;

  logic [DOT_W-1:0]          vz_mag;
  logic [DOT_W:0]            vz_rnd;
  logic [DOT_W:0]            vz_q;
  logic signed [DEPTH_W-1:0] depth;
  logic                      w_pos;

  logic [MUL_W-1:0] mag_x, mag_y;

  logic             vd_q [DIV_LAT];
  vsp_meta_t        md_q [DIV_LAT];
  logic [PIX_W-1:0] qx, qy;
  logic             ovf_x, ovf_y;

  logic     vis_x, vis_y, vis;
  vsp_out_t fin_d, fin_q;
  logic     fin_v_q;

  vsp_out_t out_q, skid_q;
  logic     out_v_q, skid_v_q, out_free;

  // configuration registers
  vsp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );
  assign pready = 1'b1;

  // the pipeline moves unless the skid entry is occupied
  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stages 1-2: dot products
  assign pos[0]  = in_data_i.pos_x;
  assign pos[1]  = in_data_i.pos_y;
  assign pos[2]  = in_data_i.pos_z;
  assign rows[0] = cfg.clip_row_x;
  assign rows[1] = cfg.clip_row_y;
  assign rows[2] = cfg.clip_row_w;
  assign rows[3] = cfg.view_row_z;

  vsp_dot u_dot (
    .clk_i (clk_i),
    .en_i  (adv),
    .pos_i (pos),
    .row_i (rows),
    .dot_o (dot)
  );

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // index follows the dot product stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx1_q <= in_data_i.vertex_index;
      idx2_q <= idx1_q;
    end
  end

  // depth: shift out coefficient fraction, round half away, saturate
  always_comb begin
    vz_mag = dot[3][DOT_W-1] ? -$unsigned(dot[3]) : $unsigned(dot[3]);
    vz_rnd = {1'b0, vz_mag} + ((DOT_W+1)'(1) << (COEF_FRAC_BITS - 1));
    vz_q   = vz_rnd >> COEF_FRAC_BITS;
    if (dot[3][DOT_W-1]) begin
      if (vz_q > (DOT_W+1)'(2**(DEPTH_W-1))) begin
        depth = DEPTH_MIN;
      end else begin
        depth = -$signed(vz_q[DEPTH_W-1:0]);
      end
    end else begin
      if (vz_q > (DOT_W+1)'(2**(DEPTH_W-1) - 1)) begin
        depth = DEPTH_MAX;
      end else begin
        depth = $signed(vz_q[DEPTH_W-1:0]);
      end
    end
    w_pos = !dot[2][DOT_W-1] && (dot[2] != '0);
  end

  // stage 3: c + w per axis
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q        <= SUM_W'(dot[0]) + SUM_W'(dot[2]);
      ay_q        <= SUM_W'(dot[1]) + SUM_W'(dot[2]);
      cw3_q       <= dot[2];
      m3_q.index  <= idx2_q;
      m3_q.depth  <= depth;
      m3_q.w_pos  <= w_pos;
      m3_q.neg_x  <= 1'b0;
      m3_q.neg_y  <= 1'b0;
    end
  end

  // stage 4: scale by window size
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q  <= MUL_W'(ax_q) * MUL_W'($signed({1'b0, cfg.screen_width}));
      my_q  <= MUL_W'(ay_q) * MUL_W'($signed({1'b0, cfg.screen_height}));
      cw4_q <= cw3_q;
      m4_q  <= m3_q;
    end
  end

  // stage 5: round(n / 2w) = floor((|n| + w) / 2w), sign kept aside
  assign mag_x = mx_q[MUL_W-1] ? -$unsigned(mx_q) : $unsigned(mx_q);
  assign mag_y = my_q[MUL_W-1] ? -$unsigned(my_q) : $unsigned(my_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q       <= mag_x[NUM_W-1:0] + NUM_W'($unsigned(cw4_q));
      ny_q       <= mag_y[NUM_W-1:0] + NUM_W'($unsigned(cw4_q));
      den_q      <= {cw4_q[DEN_W-2:0], 1'b0};
      m5_q.index <= m4_q.index;
      m5_q.depth <= m4_q.depth;
      m5_q.w_pos <= m4_q.w_pos;
      m5_q.neg_x <= mx_q[MUL_W-1];
      m5_q.neg_y <= my_q[MUL_W-1];
    end
  end

  // stages 6-18: dividers
  vsp_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (nx_q),
    .den_i  (den_q),
    .quot_o (qx),
    .ovf_o  (ovf_x)
  );

  vsp_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (ny_q),
    .den_i  (den_q),
    .quot_o (qy),
    .ovf_o  (ovf_y)
  );

  // sideband and valid alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else if (adv) begin
      vd_q[0] <= v5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      md_q[0] <= m5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        md_q[i] <= md_q[i-1];
      end
    end
  end

  // stage 19: window test; a negative value rounds onto the window only at zero
  always_comb begin
    vis_x = !ovf_x && !(md_q[DIV_LAT-1].neg_x && (qx != '0))
            && ({1'b0, qx} < cfg.screen_width);
    vis_y = !ovf_y && !(md_q[DIV_LAT-1].neg_y && (qy != '0))
            && ({1'b0, qy} < cfg.screen_height);
    vis   = md_q[DIV_LAT-1].w_pos && vis_x && vis_y;
    fin_d.index_out  = md_q[DIV_LAT-1].index;
    fin_d.screen_x   = vis ? qx : '0;
    fin_d.screen_y   = vis ? qy : '0;
    fin_d.view_depth = md_q[DIV_LAT-1].depth;
    fin_d.on_screen  = vis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (adv) begin
      fin_v_q <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q <= fin_d;
    end
  end

  // output register with skid entry
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= fin_v_q;
      end
    end else if (adv && fin_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : fin_q;
    end else if (adv) begin
      skid_q <= fin_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  `VSP_ASSERT(a_skid_only_when_out_busy, skid_v_q, out_v_q)
  `VSP_ASSERT_NXT(a_skid_holds_on_stall, skid_v_q && out_stall_i, skid_v_q)
  `VSP_ASSERT(a_offscreen_zero, out_v_q && !out_q.on_screen,
              out_q.screen_x == '0 && out_q.screen_y == '0)
  `VSP_ASSERT_NXT(a_skid_drains, skid_v_q && !out_stall_i, !skid_v_q && out_v_q)

endmodule
